[rtl/lzssd_pkg.sv]
package lzssd_pkg;

    localparam int DICT_DEPTH_DEF = 8192;

    localparam int OP_W    = 2;
    localparam int KIND_W  = 2;
    localparam int BYTE_W  = 8;
    localparam int CNT_W   = 24;
    localparam int TOK_W   = 18;
    localparam int TCNT_W  = 5;
    localparam int OFS_W   = 13;
    localparam int LEN_W   = 4;
    localparam int RUN_W   = 5;  // copy run length, up to 18

    localparam logic [RUN_W-1:0]  LEN_BIAS    = RUN_W'(3);
    localparam logic [TCNT_W-1:0] TOK_LIT_LEN = TCNT_W'(9);
    localparam logic [TCNT_W-1:0] TOK_END_LEN = TCNT_W'(14);
    localparam logic [TCNT_W-1:0] TOK_CPY_LEN = TCNT_W'(18);

    localparam logic [OP_W-1:0] OP_START = 2'd0;
    localparam logic [OP_W-1:0] OP_BYTE  = 2'd1;
    localparam logic [OP_W-1:0] OP_END   = 2'd2;

    localparam logic [KIND_W-1:0] KIND_BYTE  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_DONE  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_ERROR = 2'd2;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [BYTE_W-1:0] data;
        logic [CNT_W-1:0]  total;
    } t_result;

endpackage

[rtl/lzssd_ram.sv]
module lzssd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[rtl/lzss_bitstream_decoder.sv]
// LZSS bit-stream decoder. Compressed bytes are consumed MSB first at one bit
// per cycle, so a plain input word passes these steps from its acceptance to
// the next one: the accept, its bits one by one, a step to see the word spent
// and one to hand over its last result. A copy token adds its bytes (3 to
// 18, one byte per cycle while the output can take them), paced by the single
// read and single write port of the history RAM. A full output register holds
// the decoder wherever it has a result to hand over. End of source feeds zero
// bits at the same one-bit-per-cycle rate. Start (op 0) and reset take effect
// at once: the history RAM is not swept, entries not yet written in the
// current stream are tracked by the write head and a wrap flag and read as
// zero. DICT_DEPTH must be a power of two.
module lzss_bitstream_decoder #(
    parameter int DICT_DEPTH = lzssd_pkg::DICT_DEPTH_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    output logic                         o_in_ready,
    input  logic [lzssd_pkg::OP_W-1:0]   i_op,
    input  logic [lzssd_pkg::BYTE_W-1:0] i_stream_byte,
    output logic                         o_out_valid,
    input  logic                         i_out_ready,
    output logic [lzssd_pkg::KIND_W-1:0] o_kind,
    output logic [lzssd_pkg::BYTE_W-1:0] o_out_byte,
    output logic [lzssd_pkg::CNT_W-1:0]  o_total_written,
    output logic                         o_last_of_run,
    input  logic                         i_cfg_valid,
    output logic                         o_cfg_ready,
    input  logic [lzssd_pkg::CNT_W-1:0]  i_cfg_data
);
    import lzssd_pkg::*;

    localparam int AW = $clog2(DICT_DEPTH);

    typedef enum logic [1:0] {S_IDLE, S_BITS, S_COPY, S_FLUSH} t_state;
    typedef enum logic [1:0] {PH_IDLE, PH_RUN, PH_FIN} t_phase;
    typedef enum logic [2:0] {EV_NONE, EV_ERR, EV_LIT, EV_DONE, EV_COPY} t_event;

    t_state             r_state, n_state;
    t_phase             r_phase, n_phase;
    logic [CNT_W-1:0]   r_cap, n_cap;
    logic [AW-1:0]      r_head, n_head;
    logic               r_full, n_full;
    logic [CNT_W-1:0]   r_bw, n_bw;
    logic [TOK_W-1:0]   r_tok, n_tok;
    logic [TCNT_W-1:0]  r_cnt, n_cnt;
    logic               r_flag, n_flag;
    logic [BYTE_W-1:0]  r_sreg, n_sreg;
    logic [3:0]         r_nbits, n_nbits;
    logic               r_pad, n_pad;
    logic [AW-1:0]      r_src, n_src;
    logic [RUN_W-1:0]   r_left, n_left;
    logic [RUN_W-1:0]   r_issue, n_issue;
    logic               r_rd_pend, n_rd_pend;
    logic               r_rd_ok, n_rd_ok;
    logic               r_fwd, n_fwd;
    logic [BYTE_W-1:0]  r_fwd_data, n_fwd_data;
    t_result            r_pend, n_pend;
    logic               r_pend_valid, n_pend_valid;
    t_result            r_out, n_out;
    logic               r_out_valid, n_out_valid;
    logic               r_out_last, n_out_last;

    logic               out_free, slot_ok, produce, push, push_last;
    t_result            prod_res;
    logic               wr_en, rd_en;
    logic [BYTE_W-1:0]  wr_data, ram_q, copy_byte;
    logic               bit_b, flag, go, emit, issue;
    logic [TOK_W-1:0]   tok_nx;
    logic [TCNT_W-1:0]  cnt_nx;
    logic [RUN_W-1:0]   run_len;
    t_event             ev;

    lzssd_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (DICT_DEPTH)
    ) u_ring (
        .i_clk   (i_clk),
        .i_we    (wr_en),
        .i_waddr (r_head),
        .i_wdata (wr_data),
        .i_re    (rd_en),
        .i_raddr (r_src),
        .o_rdata (ram_q)
    );

    assign o_in_ready      = (r_state == S_IDLE);
    assign o_cfg_ready     = 1'b1;
    assign o_out_valid     = r_out_valid;
    assign o_kind          = r_out.kind;
    assign o_out_byte      = r_out.data;
    assign o_total_written = r_out.total;
    assign o_last_of_run   = r_out_last;

    assign out_free  = !r_out_valid || i_out_ready;
    assign slot_ok   = !r_pend_valid || out_free;
    assign bit_b     = r_pad ? 1'b0 : r_sreg[BYTE_W-1];
    assign flag      = (r_cnt == '0) ? bit_b : r_flag;
    assign tok_nx    = {r_tok[TOK_W-2:0], bit_b};
    assign cnt_nx    = r_cnt + TCNT_W'(1);
    assign run_len   = RUN_W'(tok_nx[LEN_W-1:0]) + LEN_BIAS;
    assign copy_byte = r_fwd ? r_fwd_data : (r_rd_ok ? ram_q : '0);

    always_comb begin
        ev = EV_NONE;
        if (flag) begin
            if (r_cnt == '0 && r_bw >= r_cap) begin
                ev = EV_ERR;
            end else if (cnt_nx == TOK_LIT_LEN) begin
                ev = EV_LIT;
            end
        end else if (cnt_nx == TOK_END_LEN && tok_nx[OFS_W-1:0] == '0) begin
            ev = EV_DONE;
        end else if (cnt_nx == TOK_CPY_LEN) begin
            if ((CNT_W+1)'(r_bw) + (CNT_W+1)'(run_len) > (CNT_W+1)'(r_cap)) begin
                ev = EV_ERR;
            end else begin
                ev = EV_COPY;
            end
        end
    end

    always_comb begin
        n_state      = r_state;
        n_phase      = r_phase;
        n_cap        = r_cap;
        n_head       = r_head;
        n_full       = r_full;
        n_bw         = r_bw;
        n_tok        = r_tok;
        n_cnt        = r_cnt;
        n_flag       = r_flag;
        n_sreg       = r_sreg;
        n_nbits      = r_nbits;
        n_pad        = r_pad;
        n_src        = r_src;
        n_left       = r_left;
        n_issue      = r_issue;
        n_rd_pend    = r_rd_pend;
        n_rd_ok      = r_rd_ok;
        n_fwd        = r_fwd;
        n_fwd_data   = r_fwd_data;
        n_pend       = r_pend;
        n_pend_valid = r_pend_valid;
        n_out        = r_out;
        n_out_valid  = r_out_valid && !i_out_ready;
        n_out_last   = r_out_last;
        produce      = 1'b0;
        prod_res     = '0;
        push         = 1'b0;
        push_last    = 1'b0;
        wr_en        = 1'b0;
        wr_data      = '0;
        rd_en        = 1'b0;
        go           = 1'b0;
        emit         = 1'b0;
        issue        = 1'b0;

        if (i_cfg_valid) begin
            n_cap = i_cfg_data;
        end

        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    case (i_op)
                        OP_START: begin
                            n_head  = AW'(1);
                            n_full  = 1'b0;
                            n_bw    = '0;
                            n_tok   = '0;
                            n_cnt   = '0;
                            n_phase = PH_RUN;
                        end
                        OP_BYTE: begin
                            if (r_phase == PH_RUN) begin
                                n_sreg  = i_stream_byte;
                                n_nbits = 4'(BYTE_W);
                                n_pad   = 1'b0;
                                n_state = S_BITS;
                            end
                        end
                        OP_END: begin
                            if (r_phase == PH_RUN) begin
                                n_pad   = 1'b1;
                                n_state = S_BITS;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            S_BITS: begin
                if (r_phase != PH_RUN || (!r_pad && r_nbits == '0)) begin
                    n_state = S_FLUSH;
                end else begin
                    go = (ev == EV_NONE || ev == EV_COPY) || slot_ok;
                    if (go) begin
                        n_sreg = {r_sreg[BYTE_W-2:0], 1'b0};
                        if (!r_pad) begin
                            n_nbits = r_nbits - 4'd1;
                        end
                        case (ev)
                            EV_NONE: begin
                                n_tok  = tok_nx;
                                n_cnt  = cnt_nx;
                                n_flag = flag;
                            end
                            EV_ERR, EV_DONE: begin
                                produce  = 1'b1;
                                prod_res = '{kind: (ev == EV_ERR) ? KIND_ERROR : KIND_DONE,
                                             data: '0, total: r_bw};
                                n_phase  = PH_FIN;
                                n_tok    = '0;
                                n_cnt    = '0;
                            end
                            EV_LIT: begin
                                produce  = 1'b1;
                                prod_res = '{kind: KIND_BYTE, data: tok_nx[BYTE_W-1:0],
                                             total: r_bw + CNT_W'(1)};
                                wr_en    = 1'b1;
                                wr_data  = tok_nx[BYTE_W-1:0];
                                n_tok    = '0;
                                n_cnt    = '0;
                            end
                            EV_COPY: begin
                                n_tok     = '0;
                                n_cnt     = '0;
                                n_src     = AW'(tok_nx[LEN_W +: OFS_W]);
                                n_left    = run_len;
                                n_issue   = run_len;
                                n_rd_pend = 1'b0;
                                n_state   = S_COPY;
                            end
                            default: ;
                        endcase
                    end
                end
            end
            S_COPY: begin
                emit = r_rd_pend && slot_ok;
                if (emit) begin
                    produce  = 1'b1;
                    prod_res = '{kind: KIND_BYTE, data: copy_byte, total: r_bw + CNT_W'(1)};
                    wr_en    = 1'b1;
                    wr_data  = copy_byte;
                    n_left   = r_left - RUN_W'(1);
                    if (r_left == RUN_W'(1)) begin
                        n_state = S_BITS;
                    end
                end
                issue = (r_issue != '0) && (!r_rd_pend || emit);
                if (issue) begin
                    rd_en      = 1'b1;
                    n_src      = r_src + AW'(1);
                    n_issue    = r_issue - RUN_W'(1);
                    // same-cycle write to the entry being read: take it from the bypass
                    n_fwd      = emit && (r_src == r_head);
                    n_fwd_data = copy_byte;
                    n_rd_ok    = r_full || (r_src != '0 && (r_src < r_head || r_head == '0));
                end
                n_rd_pend = issue || (r_rd_pend && !emit);
            end
            S_FLUSH: begin
                if (!r_pend_valid) begin
                    n_state = S_IDLE;
                end else if (out_free) begin
                    push      = 1'b1;
                    push_last = 1'b1;
                    n_state   = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase

        if (wr_en) begin
            n_head = r_head + AW'(1);
            n_bw   = r_bw + CNT_W'(1);
            if (r_head == '0) begin
                n_full = 1'b1;
            end
        end

        // a result waits in the pending register so its last flag is known before it leaves
        if (produce && r_pend_valid) begin
            push = 1'b1;
        end
        if (push) begin
            n_out       = r_pend;
            n_out_last  = push_last;
            n_out_valid = 1'b1;
        end
        if (produce) begin
            n_pend       = prod_res;
            n_pend_valid = 1'b1;
        end else if (push) begin
            n_pend_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_phase      <= PH_IDLE;
            r_cap        <= '0;
            r_head       <= AW'(1);
            r_full       <= 1'b0;
            r_bw         <= '0;
            r_tok        <= '0;
            r_cnt        <= '0;
            r_flag       <= 1'b0;
            r_nbits      <= '0;
            r_pad        <= 1'b0;
            r_left       <= '0;
            r_issue      <= '0;
            r_rd_pend    <= 1'b0;
            r_pend_valid <= 1'b0;
            r_out_valid  <= 1'b0;
            r_out_last   <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_phase      <= n_phase;
            r_cap        <= n_cap;
            r_head       <= n_head;
            r_full       <= n_full;
            r_bw         <= n_bw;
            r_tok        <= n_tok;
            r_cnt        <= n_cnt;
            r_flag       <= n_flag;
            r_nbits      <= n_nbits;
            r_pad        <= n_pad;
            r_left       <= n_left;
            r_issue      <= n_issue;
            r_rd_pend    <= n_rd_pend;
            r_pend_valid <= n_pend_valid;
            r_out_valid  <= n_out_valid;
            r_out_last   <= n_out_last;
        end
        r_sreg     <= n_sreg;
        r_src      <= n_src;
        r_rd_ok    <= n_rd_ok;
        r_fwd      <= n_fwd;
        r_fwd_data <= n_fwd_data;
        r_pend     <= n_pend;
        r_out      <= n_out;
    end

    a_idle_no_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> !r_pend_valid)
        else $error("held-back result left behind on return to idle");

    a_copy_counts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_COPY) |-> (r_left != '0 &&
            r_left == r_issue + RUN_W'(r_rd_pend)))
        else $error("copy read and emit counters out of step");

    a_copy_write_once: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_COPY && emit) |=> (r_bw == $past(r_bw) + CNT_W'(1)))
        else $error("copied byte not counted");

endmodule

[sim/tb_top.sv]
`timescale 1ns / 1ps

module tb_top;
    import lzssd_pkg::*;

    localparam int DICT      = DICT_DEPTH_DEF;
    localparam int SETTLE    = 40;     // cycles for a byte plus the longest copy to drain
    localparam int STALL_MAX = 4000;   // cycles with no handshake at all
    localparam int HOLD_LEN  = 400;    // long output hold-off in the last phase
    localparam int MAX_SHOWN = 10;

    typedef enum logic [1:0] {ST_IDLE, ST_RUN, ST_FIN} t_strm_state;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [BYTE_W-1:0] data;
        logic [CNT_W-1:0]  total;
        logic              last;
    } t_dec_word;

    typedef struct packed {
        bit                is_cfg;
        logic [OP_W-1:0]   op;
        logic [BYTE_W-1:0] data;
        logic [CNT_W-1:0]  cap;
        bit                typed;
        bit                has_word;
        t_dec_word         word;
    } t_stim_row;

    logic                i_clk;
    logic                i_rst_n;
    logic                i_in_valid;
    logic                o_in_ready;
    logic [OP_W-1:0]     i_op;
    logic [BYTE_W-1:0]   i_stream_byte;
    logic                o_out_valid;
    logic                i_out_ready;
    logic [KIND_W-1:0]   o_kind;
    logic [BYTE_W-1:0]   o_out_byte;
    logic [CNT_W-1:0]    o_total_written;
    logic                o_last_of_run;
    logic                i_cfg_valid;
    logic                o_cfg_ready;
    logic [CNT_W-1:0]    i_cfg_data;

    // decoder model state
    logic [BYTE_W-1:0]   dict_mem [DICT];
    logic [OFS_W-1:0]    dict_head;
    logic [CNT_W-1:0]    out_count;
    logic [TOK_W-1:0]    tok_bits;
    logic [TCNT_W-1:0]   tok_cnt;
    t_strm_state         strm_state;
    logic [CNT_W-1:0]    cap_limit;

    t_dec_word           item_words[$];
    t_dec_word           decode_q[$];
    t_stim_row           dir_tab[$];

    bit                  row_typed;
    bit                  row_has_word;
    t_dec_word           row_word;
    bit                  hold_req;
    int unsigned         in_idle_pct = 11;
    int unsigned         out_idle_pct = 84;
    int                  useful_items;
    int                  bad;
    int                  n_in;
    int                  n_words;
    int                  n_done;
    int                  n_err;

    lzss_bitstream_decoder i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_op            (i_op),
        .i_stream_byte   (i_stream_byte),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_kind          (o_kind),
        .o_out_byte      (o_out_byte),
        .o_total_written (o_total_written),
        .o_last_of_run   (o_last_of_run),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_data      (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic void dec_emit(logic [KIND_W-1:0] kind, logic [BYTE_W-1:0] data);
        t_dec_word w;
        w.kind  = kind;
        w.data  = data;
        w.total = out_count;
        w.last  = 1'b0;
        item_words.push_back(w);
    endfunction

    function automatic void dec_put_byte(logic [BYTE_W-1:0] v);
        out_count = out_count + 1'b1;
        dec_emit(KIND_BYTE, v);
        dict_mem[dict_head] = v;
        dict_head = dict_head + 1'b1;
    endfunction

    function automatic void dec_close(logic [KIND_W-1:0] kind);
        dec_emit(kind, '0);
        strm_state = ST_FIN;
        tok_bits   = '0;
        tok_cnt    = '0;
    endfunction

    function automatic void dec_clear();
        foreach (dict_mem[i]) dict_mem[i] = '0;
        dict_head = OFS_W'(1);
        out_count = '0;
        tok_bits  = '0;
        tok_cnt   = '0;
    endfunction

    function automatic void dec_shift_bit(logic b);
        logic [OFS_W-1:0] ofs;
        logic [RUN_W-1:0] run;
        if (strm_state != ST_RUN) return;
        tok_bits = {tok_bits[TOK_W-2:0], b};
        tok_cnt  = tok_cnt + 1'b1;
        if (tok_bits[tok_cnt - 1'b1]) begin
            // literal: capacity is checked on the flag bit itself
            if (tok_cnt == 1 && out_count >= cap_limit) begin
                dec_close(KIND_ERROR);
            end else if (tok_cnt == TOK_LIT_LEN) begin
                dec_put_byte(tok_bits[BYTE_W-1:0]);
                tok_bits = '0;
                tok_cnt  = '0;
            end
        end else if (tok_cnt == TOK_END_LEN) begin
            if (tok_bits[OFS_W-1:0] == '0) dec_close(KIND_DONE);
        end else if (tok_cnt == TOK_CPY_LEN) begin
            ofs = tok_bits[LEN_W +: OFS_W];
            run = RUN_W'(tok_bits[LEN_W-1:0]) + LEN_BIAS;
            tok_bits = '0;
            tok_cnt  = '0;
            if (25'(out_count) + 25'(run) > 25'(cap_limit)) begin
                dec_close(KIND_ERROR);
            end else begin
                // reads may hit entries written earlier in this same copy
                for (int i = 0; i < int'(run); i++) dec_put_byte(dict_mem[OFS_W'(ofs + i)]);
            end
        end
    endfunction

    function automatic void dec_apply_item(logic [OP_W-1:0] op, logic [BYTE_W-1:0] data);
        item_words.delete();
        case (op)
            OP_START: begin
                dec_clear();
                strm_state = ST_RUN;
            end
            OP_BYTE: begin
                for (int k = BYTE_W - 1; k >= 0; k--) dec_shift_bit(data[k]);
            end
            OP_END: begin
                while (strm_state == ST_RUN) dec_shift_bit(1'b0);
            end
            default: ;
        endcase
        if (item_words.size() > 0) item_words[item_words.size() - 1].last = 1'b1;
    endfunction

    function automatic void tab_row(logic [OP_W-1:0] op, logic [BYTE_W-1:0] data, bit typed,
                                    bit has_word = 1'b0, logic [KIND_W-1:0] kind = KIND_BYTE,
                                    logic [BYTE_W-1:0] ob = '0, logic [CNT_W-1:0] total = '0);
        t_stim_row r;
        r = '0;
        r.op         = op;
        r.data       = data;
        r.typed      = typed;
        r.has_word   = has_word;
        r.word.kind  = kind;
        r.word.data  = ob;
        r.word.total = total;
        r.word.last  = 1'b1;
        dir_tab.push_back(r);
    endfunction

    function automatic void tab_cfg(logic [CNT_W-1:0] v);
        t_stim_row r;
        r = '0;
        r.is_cfg = 1'b1;
        r.cap    = v;
        dir_tab.push_back(r);
    endfunction

    // starts at a falling edge, returns just after the accepting rising edge
    task automatic send_word(logic [OP_W-1:0] op, logic [BYTE_W-1:0] data,
                             bit typed = 1'b0, bit has_word = 1'b0, t_dec_word word = '0);
        @(negedge i_clk);
        while ($urandom_range(99) < in_idle_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        if (op == OP_START || ((op == OP_BYTE || op == OP_END) && strm_state == ST_RUN))
            useful_items++;
        row_typed     = typed;
        row_has_word  = has_word;
        row_word      = word;
        i_in_valid    <= 1'b1;
        i_op          <= op;
        i_stream_byte <= data;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
    endtask

    task automatic write_capacity(logic [CNT_W-1:0] v);
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (decode_q.size() != 0) @(negedge i_clk);
        repeat (SETTLE) @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= v;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // one compressed stream: random tokens packed MSB first, random tail bits
    task automatic run_stream();
        bit                tok_q[$];
        logic [BYTE_W-1:0] pk;
        logic [OFS_W-1:0]  ofs;
        logic [LEN_W-1:0]  len;
        int                ntok;
        int                r;
        ntok = $urandom_range(1, 6);
        for (int t = 0; t < ntok; t++) begin
            r = $urandom_range(99);
            if (r < 45) begin
                pk = BYTE_W'($urandom);
                tok_q.push_back(1'b1);
                for (int k = BYTE_W - 1; k >= 0; k--) tok_q.push_back(pk[k]);
            end else begin
                ofs = '0;
                if (r < 94)
                    ofs = ($urandom_range(3) == 0) ? OFS_W'($urandom_range(1, DICT - 1))
                                                   : OFS_W'($urandom_range(1, 48));
                tok_q.push_back(1'b0);
                for (int k = OFS_W - 1; k >= 0; k--) tok_q.push_back(ofs[k]);
                if (ofs != '0) begin
                    len = ($urandom_range(3) == 0) ? '1 : LEN_W'($urandom);
                    for (int k = LEN_W - 1; k >= 0; k--) tok_q.push_back(len[k]);
                end
            end
        end
        if ($urandom_range(99) < 92) send_word(OP_START, BYTE_W'($urandom));
        while (tok_q.size() > 0) begin
            if ($urandom_range(99) < 6) send_word(OP_W'($urandom), BYTE_W'($urandom));
            pk = BYTE_W'($urandom);
            for (int k = BYTE_W - 1; k >= 0; k--)
                if (tok_q.size() > 0) pk[k] = tok_q.pop_front();
            send_word(OP_BYTE, pk);
        end
        if ($urandom_range(99) < 85) send_word(OP_END, BYTE_W'($urandom));
    endtask

    always @(posedge i_clk) begin
        t_dec_word got;
        t_dec_word want;
        if (i_rst_n) begin
            if (i_cfg_valid && o_cfg_ready) cap_limit = i_cfg_data;
            if (i_in_valid && o_in_ready) begin
                n_in++;
                dec_apply_item(i_op, i_stream_byte);
                if (!row_typed) begin
                    foreach (item_words[k]) decode_q.push_back(item_words[k]);
                end else if (row_has_word) begin
                    decode_q.push_back(row_word);
                end
            end
            if (o_out_valid && i_out_ready) begin
                got.kind  = o_kind;
                got.data  = o_out_byte;
                got.total = o_total_written;
                got.last  = o_last_of_run;
                n_words++;
                if (decode_q.size() == 0) begin
                    bad++;
                    if (bad <= MAX_SHOWN)
                        $display("%0t: unexpected word kind %0d byte %02h total %0d last %0d",
                                 $realtime, got.kind, got.data, got.total, got.last);
                end else begin
                    want = decode_q.pop_front();
                    if (want.kind == KIND_DONE) n_done++;
                    if (want.kind == KIND_ERROR) n_err++;
                    if (got !== want) begin
                        bad++;
                        if (bad <= MAX_SHOWN) begin
                            $write("%0t: mismatch exp kind %0d byte %02h total %0d last %0d,",
                                   $realtime, want.kind, want.data, want.total, want.last);
                            $display(" got kind %0d byte %02h total %0d last %0d",
                                     got.kind, got.data, got.total, got.last);
                        end
                    end
                end
            end
        end
    end

    initial begin
        i_out_ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                i_out_ready <= 1'b0;
                repeat (HOLD_LEN) @(negedge i_clk);
                hold_req = 1'b0;
            end else begin
                i_out_ready <= ($urandom_range(99) >= out_idle_pct);
            end
        end
    end

    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < STALL_MAX) begin
            @(posedge i_clk);
            if (!i_rst_n || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready) ||
                (i_cfg_valid && o_cfg_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("%0t: no handshake for %0d cycles", $realtime, STALL_MAX);
        $display("CHECKS FAILED");
        $finish;
    end

    initial begin
        i_rst_n       = 1'b0;
        i_in_valid    = 1'b0;
        i_op          = OP_START;
        i_stream_byte = '0;
        i_cfg_valid   = 1'b0;
        i_cfg_data    = '0;
        row_typed     = 1'b0;
        row_has_word  = 1'b0;
        row_word      = '0;
        hold_req      = 1'b0;
        bad           = 0;
        n_in          = 0;
        n_words       = 0;
        n_done        = 0;
        n_err         = 0;
        dec_clear();
        strm_state    = ST_IDLE;
        cap_limit     = '0;

        // capacity still at reset (zero): nothing runs before a start
        tab_row(OP_BYTE,  8'hFF, 1);
        tab_row(OP_END,   8'h00, 1);
        tab_row(2'b11,    8'hAA, 1);
        tab_row(OP_START, 8'hA5, 1);
        tab_row(OP_BYTE,  8'h80, 1, 1, KIND_ERROR, 8'h00, 24'd0);
        tab_row(OP_BYTE,  8'h55, 1);
        tab_row(OP_END,   8'h00, 1);
        // full capacity: literals 0xFF and 0x00 straddling words, then end token
        tab_cfg(24'hFF_FFFF);
        tab_row(OP_START, 8'h00, 1);
        tab_row(OP_BYTE,  8'hFF, 1);
        tab_row(OP_BYTE,  8'hC0, 1, 1, KIND_BYTE, 8'hFF, 24'd1);
        tab_row(OP_BYTE,  8'h00, 1, 1, KIND_BYTE, 8'h00, 24'd2);
        tab_row(OP_BYTE,  8'h00, 1, 1, KIND_DONE, 8'h00, 24'd2);
        // literal then an 18-byte copy overlapping the head, closed by end of source
        tab_row(OP_START, 8'h00, 0);
        tab_row(OP_BYTE,  8'hA0, 0);
        tab_row(OP_BYTE,  8'h80, 0);
        tab_row(OP_BYTE,  8'h03, 0);
        tab_row(OP_BYTE,  8'hE0, 0);
        tab_row(OP_END,   8'h00, 0);
        // capacity 4: first copy fills it exactly, second one overflows
        tab_cfg(24'd4);
        tab_row(OP_START, 8'h00, 0);
        tab_row(OP_BYTE,  8'hAD, 0);
        tab_row(OP_BYTE,  8'h00, 0);
        tab_row(OP_BYTE,  8'h02, 0);
        tab_row(OP_BYTE,  8'h00, 0);
        tab_row(OP_BYTE,  8'h00, 0);
        tab_row(OP_BYTE,  8'h80, 1, 1, KIND_ERROR, 8'h00, 24'd4);

        repeat (4) @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (dir_tab[r]) begin
            if (dir_tab[r].is_cfg)
                write_capacity(dir_tab[r].cap);
            else
                send_word(dir_tab[r].op, dir_tab[r].data, dir_tab[r].typed,
                          dir_tab[r].has_word, dir_tab[r].word);
        end

        write_capacity(24'hFF_FFFF);
        useful_items = 0;
        while (useful_items < 22) run_stream();

        in_idle_pct  = 84;
        out_idle_pct = 11;
        write_capacity(CNT_W'($urandom_range(8, 40)));
        useful_items = 0;
        while (useful_items < 22) run_stream();

        in_idle_pct  = 0;
        out_idle_pct = 0;
        write_capacity(CNT_W'($urandom_range(30, 120)));
        hold_req = 1'b1;
        useful_items = 0;
        while (useful_items < 22) run_stream();

        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (decode_q.size() != 0) @(negedge i_clk);
        repeat (SETTLE) @(negedge i_clk);
        bad += decode_q.size();

        $display("covered %0d input words and %0d output words (%0d stream ends, %0d overflows)",
                 n_in, n_words, n_done, n_err);
        $display("capacities zero, 4, max and small random ones; long output hold-off applied");
        if (bad == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

[files.f]
rtl/lzssd_pkg.sv
rtl/lzssd_ram.sv
rtl/lzss_bitstream_decoder.sv
sim/tb_top.sv
